// File: hw/rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants for the aarch64 relocation patcher
// Action codes, status codes, instruction field masks and the word that
// travels from the operand stage to the patch stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  // relocation action codes
  typedef enum logic [3:0] {
    OP_PCREL32     = 4'd0,
    OP_ABS64       = 4'd1,
    OP_ABS32       = 4'd2,
    OP_BRANCH26    = 4'd3,
    OP_PAGE21      = 4'd4,
    OP_PAGEOFF12   = 4'd5,
    OP_LDST64      = 4'd6,
    OP_LDST32      = 4'd7,
    OP_LDST128     = 4'd8,
    OP_CONDBR19    = 4'd9,
    OP_GOTPAGE21   = 4'd10,
    OP_GOTPAGEOFF12 = 4'd11
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  // instruction field masks
  localparam logic [31:0] BR26_KEEP    = 32'hFC00_0000;
  localparam logic [31:0] ADRP_KEEP    = 32'h9F00_001F;
  localparam logic [31:0] LDST_CLASS_M = 32'h3B00_0000;
  localparam logic [31:0] LDST_CLASS_V = 32'h3900_0000;
  localparam logic [31:0] SIMD128_M    = 32'h0480_0000;
  localparam logic [31:0] LDST_KEEP    = 32'hFFC0_03FF;
  localparam logic [31:0] ADD_IMM_BASE = 32'h9100_0000;
  localparam logic [31:0] CB19_KEEP    = 32'hFF00_001F;

  // load/store offset scales
  localparam logic [2:0] SCALE_32  = 3'd2;
  localparam logic [2:0] SCALE_64  = 3'd3;
  localparam logic [2:0] SCALE_128 = 3'd4;

  // operand stage word: target already formed as base plus addend
  typedef struct packed {
    logic [3:0]  op;
    logic [63:0] target;
    logic [63:0] place;
    logic [31:0] insn;
    logic        got_ok;
    logic        got_any;
    logic        named;
    logic        writable;
  } stage_t;

endpackage

`default_nettype wire

// File: hw/rtl/arp_patch_unit.sv
// ----------------------------------------------------------------------------
// arp_patch_unit: displacement, range check and field insertion
// Takes the registered operand word, forms the pc- or page-relative
// displacement, checks its range, builds the patched value and registers
// the result together with its strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_patch_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire arp_pkg::stage_t   stage_i,
  output logic                   done_o,
  output logic [63:0]            patch_value_o,
  output logic                   patch_is_wide_o,
  output logic [1:0]             status_o,
  output logic                   needs_bind_o,
  output logic                   needs_rebase_o
);

  // insert a scaled low-12 page offset into a load/store word
  function automatic logic [31:0] lo12_insert(input logic [31:0] insn,
                                              input logic [11:0] low,
                                              input logic [2:0]  scale);
    logic [11:0] off;
    off = low >> scale;
    return (insn & arp_pkg::LDST_KEEP) | {10'b0, off, 10'b0};
  endfunction

  logic        is_page;
  logic [63:0] lhs;
  logic [63:0] rhs;
  logic [63:0] diff;
  logic        br26_fit;
  logic        cb19_fit;
  logic        adrp_fit;
  logic [31:0] adrp_word;
  logic [2:0]  auto_scale;
  logic [63:0] val;
  logic        wide;
  logic        bind_req;
  logic        rebase;
  logic        fit;
  logic [1:0]  status;

  logic        done_q;
  logic [63:0] value_q;
  logic        wide_q;
  logic [1:0]  status_q;
  logic        bind_q;
  logic        rebase_q;

  // displacement: page-aligned for adrp forms, plain otherwise
  assign is_page = (stage_i.op == arp_pkg::OP_PAGE21) || (stage_i.op == arp_pkg::OP_GOTPAGE21);
  assign lhs  = is_page ? {stage_i.target[63:12], 12'b0} : stage_i.target;
  assign rhs  = is_page ? {stage_i.place[63:12], 12'b0} : stage_i.place;
  assign diff = lhs - rhs;

  // range checks: the bits above the field must be a sign extension
  assign br26_fit = (&diff[63:27]) || !(|diff[63:27]);
  assign cb19_fit = (&diff[63:20]) || !(|diff[63:20]);
  assign adrp_fit = (&diff[63:32]) || !(|diff[63:32]);

  assign adrp_word = (stage_i.insn & arp_pkg::ADRP_KEEP) |
                     {1'b0, diff[13:12], 24'b0, 5'b0} |
                     {8'b0, diff[32:14], 5'b0};

  // scale detection for the generic page-offset form
  always_comb begin
    auto_scale = 3'd0;
    if ((stage_i.insn & arp_pkg::LDST_CLASS_M) == arp_pkg::LDST_CLASS_V) begin
      auto_scale = {1'b0, stage_i.insn[31:30]};
      if ((stage_i.insn & arp_pkg::SIMD128_M) == arp_pkg::SIMD128_M) begin
        auto_scale = arp_pkg::SCALE_128;
      end
    end
  end

  // action select
  always_comb begin
    val      = 64'd0;
    wide     = 1'b0;
    bind_req = 1'b0;
    rebase   = 1'b0;
    fit      = 1'b1;
    status   = arp_pkg::ST_OK;
    case (stage_i.op)
      arp_pkg::OP_PCREL32: begin
        val = {32'b0, diff[31:0]};
      end
      arp_pkg::OP_ABS64: begin
        wide = 1'b1;
        if (stage_i.named && stage_i.writable && stage_i.got_any) begin
          bind_req = 1'b1;
        end else begin
          val    = stage_i.target;
          rebase = stage_i.writable && (|stage_i.target);
        end
      end
      arp_pkg::OP_ABS32: begin
        val = {32'b0, stage_i.target[31:0]};
      end
      arp_pkg::OP_BRANCH26: begin
        fit = br26_fit;
        val = {32'b0, (stage_i.insn & arp_pkg::BR26_KEEP) | {6'b0, diff[27:2]}};
      end
      arp_pkg::OP_PAGE21, arp_pkg::OP_GOTPAGE21: begin
        fit = adrp_fit;
        val = {32'b0, adrp_word};
      end
      arp_pkg::OP_PAGEOFF12: begin
        val = {32'b0, lo12_insert(stage_i.insn, stage_i.target[11:0], auto_scale)};
      end
      arp_pkg::OP_LDST64: begin
        val = {32'b0, lo12_insert(stage_i.insn, stage_i.target[11:0], arp_pkg::SCALE_64)};
      end
      arp_pkg::OP_LDST32: begin
        val = {32'b0, lo12_insert(stage_i.insn, stage_i.target[11:0], arp_pkg::SCALE_32)};
      end
      arp_pkg::OP_LDST128: begin
        val = {32'b0, lo12_insert(stage_i.insn, stage_i.target[11:0], arp_pkg::SCALE_128)};
      end
      arp_pkg::OP_CONDBR19: begin
        fit = cb19_fit;
        val = {32'b0, (stage_i.insn & arp_pkg::CB19_KEEP) | {8'b0, diff[20:2], 5'b0}};
      end
      arp_pkg::OP_GOTPAGEOFF12: begin
        if (stage_i.got_ok) begin
          val = {32'b0, lo12_insert(stage_i.insn, stage_i.target[11:0], arp_pkg::SCALE_64)};
        end else begin
          // relax the got load into add xd, xn, #pageoff
          val = {32'b0, arp_pkg::ADD_IMM_BASE | {10'b0, stage_i.target[11:0], 10'b0} |
                        {22'b0, stage_i.insn[9:5], 5'b0} | {27'b0, stage_i.insn[4:0]}};
        end
      end
      default: begin
        status = arp_pkg::ST_UNKNOWN;
      end
    endcase
    if ((status == arp_pkg::ST_OK) && !fit) begin
      status = arp_pkg::ST_RANGE;
    end
    // nothing to store on an error
    if (status != arp_pkg::ST_OK) begin
      val      = 64'd0;
      wide     = 1'b0;
      bind_req = 1'b0;
      rebase   = 1'b0;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      value_q  <= val;
      wide_q   <= wide;
      status_q <= status;
      bind_q   <= bind_req;
      rebase_q <= rebase;
    end
  end

  assign done_o          = done_q;
  assign patch_value_o   = value_q;
  assign patch_is_wide_o = wide_q;
  assign status_o        = status_q;
  assign needs_bind_o    = bind_q;
  assign needs_rebase_o  = rebase_q;

endmodule

`default_nettype wire

// File: hw/rtl/aarch64_reloc_patcher_top.sv
// ----------------------------------------------------------------------------
// aarch64_reloc_patcher_top: applies one classified aarch64 relocation
// Registers the relocation, adds the addend to the symbol or got base,
// then forms the displacement and patches the instruction or data word.
// ----------------------------------------------------------------------------
// A relocation word is taken at every clock edge where start is high; busy
// never rises, so one word per cycle is sustained. Each word produces
// exactly one result, shown for one cycle with done_o high, in the order
// the words came in. A word passes through the input register, the operand
// register (symbol or got base plus addend) and the displacement/patch
// register; the receiver cannot hold a result off, so done_o words must be
// captured as they appear.
`timescale 1ns / 1ps
`default_nettype none

module aarch64_reloc_patcher_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  operation_i,
  input  wire logic [63:0] symbol_address_i,
  input  wire logic signed [63:0] addend_i,
  input  wire logic [63:0] place_address_i,
  input  wire logic [31:0] old_word_i,
  input  wire logic        got_exists_i,
  input  wire logic [63:0] got_address_i,
  input  wire logic        symbol_named_i,
  input  wire logic        target_writable_i,
  output logic             done_o,
  output logic [63:0]      patch_value_o,
  output logic             patch_is_wide_o,
  output logic [1:0]       status_o,
  output logic             needs_bind_o,
  output logic             needs_rebase_o
);

  logic        in_vld_q;
  logic [3:0]  op_q;
  logic [63:0] sym_q;
  logic [63:0] addend_q;
  logic [63:0] place_q;
  logic [31:0] insn_q;
  logic        got_any_q;
  logic [63:0] got_q;
  logic        named_q;
  logic        writable_q;

  logic            got_ok;
  logic            use_got;
  logic [63:0]     base;
  arp_pkg::stage_t stage_d;
  arp_pkg::stage_t stage_q;
  logic            stage_vld_q;

  // every word is taken
  assign busy = 1'b0;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      stage_vld_q <= 1'b0;
    end else begin
      in_vld_q    <= start && !busy;
      stage_vld_q <= in_vld_q;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      op_q       <= operation_i;
      sym_q      <= symbol_address_i;
      addend_q   <= addend_i;
      place_q    <= place_address_i;
      insn_q     <= old_word_i;
      got_any_q  <= got_exists_i;
      got_q      <= got_address_i;
      named_q    <= symbol_named_i;
      writable_q <= target_writable_i;
    end
  end

  // operand stage: a present, nonzero got entry replaces the symbol for the got forms
  assign got_ok  = got_any_q && (|got_q);
  assign use_got = got_ok && ((op_q == arp_pkg::OP_GOTPAGE21) ||
                              (op_q == arp_pkg::OP_GOTPAGEOFF12));
  assign base    = use_got ? got_q : sym_q;

  always_comb begin
    stage_d          = '0;
    stage_d.op       = op_q;
    stage_d.target   = base + addend_q;
    stage_d.place    = place_q;
    stage_d.insn     = insn_q;
    stage_d.got_ok   = got_ok;
    stage_d.got_any  = got_any_q;
    stage_d.named    = named_q;
    stage_d.writable = writable_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      stage_q <= stage_d;
    end
  end

  // displacement and patch stage
  arp_patch_unit u_patch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vld_i           (stage_vld_q),
    .stage_i         (stage_q),
    .done_o          (done_o),
    .patch_value_o   (patch_value_o),
    .patch_is_wide_o (patch_is_wide_o),
    .status_o        (status_o),
    .needs_bind_o    (needs_bind_o),
    .needs_rebase_o  (needs_rebase_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker: port-level checks for the relocation patcher
// Watches the top level ports for result timing and result consistency,
// attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [63:0] patch_value_o,
  input wire logic        patch_is_wide_o,
  input wire logic [1:0]  status_o,
  input wire logic        needs_bind_o,
  input wire logic        needs_rebase_o
);

  // every accepted word yields a result after the input, operand and patch registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("accepted word gave no result");

  // an error result stores nothing and raises no flag
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != arp_pkg::ST_OK)) |->
      ((patch_value_o == 64'd0) && !patch_is_wide_o && !needs_bind_o && !needs_rebase_o))
    else $error("error result carries data");

  // a bind writes a zero pointer and never a rebase
  a_bind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && needs_bind_o) |->
      ((patch_value_o == 64'd0) && patch_is_wide_o && !needs_rebase_o))
    else $error("bind result inconsistent");

  // a rebase only for a nonzero wide pointer
  a_rebase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && needs_rebase_o) |-> (patch_is_wide_o && (patch_value_o != 64'd0)))
    else $error("rebase result inconsistent");

endmodule

bind aarch64_reloc_patcher_top arp_checker u_arp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .patch_value_o   (patch_value_o),
  .patch_is_wide_o (patch_is_wide_o),
  .status_o        (status_o),
  .needs_bind_o    (needs_bind_o),
  .needs_rebase_o  (needs_rebase_o)
);

`default_nettype wire
